// ===== hdl/ntw_pkg.sv =====
// ----------------------------------------------------------------------------
// Number-to-word-tokens package
// Widths, token codes and decimal place values shared by the channel
// interfaces and the conversion pipeline.
// ----------------------------------------------------------------------------
package ntw_pkg;

   // Payload widths.
   localparam int VALUE_W = 31;
   localparam int WORD_W  = 5;

   // Decimal digits of a 31-bit value, and the fixed word slots of a spelling.
   localparam int NUM_DIGITS = 10;
   localparam int DIGIT_W    = 4;
   localparam int NUM_SLOTS  = 16;

   // Width that holds nine times the largest place value.
   localparam int CMP_W = 34;

   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [WORD_W-1:0]  token_type;
   typedef logic [DIGIT_W-1:0] digit_type;

   // Word tokens with a name of their own.
   localparam token_type TOK_ZERO     = 5'd0;
   localparam token_type TOK_TEN      = 5'd10;
   localparam token_type TOK_TENS_OFS = 5'd18;
   localparam token_type TOK_HUNDRED  = 5'd28;
   localparam token_type TOK_THOUSAND = 5'd29;
   localparam token_type TOK_MILLION  = 5'd30;
   localparam token_type TOK_BILLION  = 5'd31;

   // Place value of each digit, most significant first.
   localparam logic [CMP_W-1:0] POW10 [NUM_DIGITS] = '{
      34'd1000000000, 34'd100000000, 34'd10000000, 34'd1000000, 34'd100000,
      34'd10000,      34'd1000,      34'd100,      34'd10,       34'd1
   };

endpackage

// ===== hdl/ntw_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one value to be spelled out.
// ----------------------------------------------------------------------------
interface ntw_req_if;

   logic                valid;
   logic                ready;
   ntw_pkg::value_type  value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);

endinterface

// ===== hdl/ntw_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one word token and its last-word marker.
// ----------------------------------------------------------------------------
interface ntw_rsp_if;

   logic                valid;
   logic                ready;
   ntw_pkg::token_type  word;
   logic                last_word;

   modport source (output valid, output word, output last_word, input ready);
   modport sink   (input valid, input word, input last_word, output ready);

endinterface

// ===== hdl/number_to_word_tokens.sv =====
// ----------------------------------------------------------------------------
// Number to word tokens
// Spells a 31-bit unsigned value as a run of English word tokens.
// ----------------------------------------------------------------------------
// Each request carries one value; the block answers with one to sixteen word
// tokens on the response channel, one per cycle while the receiver is ready,
// the final one marked with last_word. A request passes an input register
// and ten digit stages (one decimal digit per stage, most significant first)
// before its words reach the output register. The pipeline takes a new
// request every cycle while the output register keeps up; a request occupies
// the output register until its last word is taken, so a long spelling holds
// back the requests behind it.
// ----------------------------------------------------------------------------
module number_to_word_tokens (
   input  logic         clock,
   input  logic         reset,
   ntw_req_if.sink      req_ch,
   ntw_rsp_if.source    rsp_ch
);

   localparam int LAST_STG = ntw_pkg::NUM_DIGITS;

   // Stage 0 is the input register; stage s (1..10) has resolved s digits.
   logic [LAST_STG:0]   vld_ff;
   logic [LAST_STG:0]   adv;
   ntw_pkg::value_type  rem_ff [LAST_STG];
   ntw_pkg::digit_type  dig_ff [1:LAST_STG][ntw_pkg::NUM_DIGITS];

   // Output register: one token per word slot and a mask of pending slots.
   logic [ntw_pkg::NUM_SLOTS-1:0] mask_ff;
   logic [ntw_pkg::NUM_SLOTS-1:0] mask_in;
   ntw_pkg::token_type            tok_ff [ntw_pkg::NUM_SLOTS];
   ntw_pkg::token_type            tok_in [ntw_pkg::NUM_SLOTS];

   logic [ntw_pkg::NUM_SLOTS-1:0] slot_vld;
   ntw_pkg::token_type            slot_tok [ntw_pkg::NUM_SLOTS];
   logic [ntw_pkg::NUM_SLOTS-1:0] low_bit;
   logic                          rsp_fire;
   logic                          ser_free;

   // A stage moves forward when it is empty or the next stage moves too.
   always_comb begin
      adv[LAST_STG] = !vld_ff[LAST_STG] || ser_free;
      for (int s = LAST_STG - 1; s >= 0; s--) begin
         adv[s] = !vld_ff[s] || adv[s+1];
      end
   end

   assign req_ch.ready = adv[0];

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv[0]) begin
         vld_ff[0] <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         rem_ff[0] <= req_ch.value;
      end
   end

   // Digit stages: each finds one decimal digit by comparing the remainder
   // against the nine multiples of its place value, then subtracts.
   for (genvar s = 1; s <= LAST_STG; s++) begin : g_digit
      ntw_pkg::digit_type           dig_in [ntw_pkg::NUM_DIGITS];
      ntw_pkg::digit_type           digit;
      logic [ntw_pkg::CMP_W-1:0]    sub;

      always_comb begin
         digit = '0;
         sub   = '0;
         for (int d = 1; d <= 9; d++) begin
            if ({{(ntw_pkg::CMP_W - ntw_pkg::VALUE_W){1'b0}}, rem_ff[s-1]} >=
                ntw_pkg::CMP_W'(d) * ntw_pkg::POW10[s-1]) begin
               digit = ntw_pkg::DIGIT_W'(d);
               sub   = ntw_pkg::CMP_W'(d) * ntw_pkg::POW10[s-1];
            end
         end
      end

      // Earlier digits ride along with the remainder.
      if (s == 1) begin : g_first
         always_comb begin
            for (int k = 0; k < ntw_pkg::NUM_DIGITS; k++) begin
               dig_in[k] = '0;
            end
            dig_in[0] = digit;
         end
      end else begin : g_rest
         always_comb begin
            for (int k = 0; k < ntw_pkg::NUM_DIGITS; k++) begin
               dig_in[k] = dig_ff[s-1][k];
            end
            dig_in[s-1] = digit;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv[s]) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[s]) begin
            dig_ff[s] <= dig_in;
         end
      end

      // The last stage leaves no remainder behind.
      if (s < LAST_STG) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv[s]) begin
               rem_ff[s] <= rem_ff[s-1] - ntw_pkg::VALUE_W'(sub);
            end
         end
      end
   end

   // Word slots from the ten digits: billions digit and scale, then for the
   // millions, thousands and units groups the hundreds digit, Hundred, teen or
   // tens word, unit word after a tens word, and scale word (none for units).
   always_comb begin
      ntw_pkg::digit_type h;
      ntw_pkg::digit_type t;
      ntw_pkg::digit_type u;
      logic               all_zero;
      int                 b;

      slot_vld = '0;
      for (int i = 0; i < ntw_pkg::NUM_SLOTS; i++) begin
         slot_tok[i] = ntw_pkg::TOK_ZERO;
      end

      all_zero = 1'b1;
      for (int k = 0; k < ntw_pkg::NUM_DIGITS; k++) begin
         if (dig_ff[LAST_STG][k] != '0) begin
            all_zero = 1'b0;
         end
      end

      // A value of zero spells as the single word Zero.
      slot_vld[0] = all_zero || (dig_ff[LAST_STG][0] != '0);
      slot_tok[0] = {1'b0, dig_ff[LAST_STG][0]};
      slot_vld[1] = dig_ff[LAST_STG][0] != '0;
      slot_tok[1] = ntw_pkg::TOK_BILLION;

      for (int g = 0; g < 3; g++) begin
         b = 2 + 5 * g;
         h = dig_ff[LAST_STG][1 + 3 * g];
         t = dig_ff[LAST_STG][2 + 3 * g];
         u = dig_ff[LAST_STG][3 + 3 * g];

         slot_vld[b]   = h != '0;
         slot_tok[b]   = {1'b0, h};
         slot_vld[b+1] = h != '0;
         slot_tok[b+1] = ntw_pkg::TOK_HUNDRED;

         // Teens and single units take one word; twenty and up take a tens
         // word and, unless round, a unit word.
         slot_vld[b+2] = (t != '0) || (u != '0);
         if (t >= 4'd2) begin
            slot_tok[b+2] = ntw_pkg::TOK_TENS_OFS + {1'b0, t};
         end else if (t == 4'd1) begin
            slot_tok[b+2] = ntw_pkg::TOK_TEN + {1'b0, u};
         end else begin
            slot_tok[b+2] = {1'b0, u};
         end
         slot_vld[b+3] = (t >= 4'd2) && (u != '0);
         slot_tok[b+3] = {1'b0, u};

         if (g < 2) begin
            slot_vld[b+4] = (h != '0) || (t != '0) || (u != '0);
            slot_tok[b+4] = (g == 0) ? ntw_pkg::TOK_MILLION : ntw_pkg::TOK_THOUSAND;
         end
      end
   end

   // Output register: the lowest pending slot is the word on offer.
   always_comb begin
      low_bit          = mask_ff & (~mask_ff + 1'b1);
      rsp_ch.valid     = |mask_ff;
      rsp_ch.last_word = (mask_ff & ~low_bit) == '0;
      rsp_ch.word      = '0;
      for (int i = 0; i < ntw_pkg::NUM_SLOTS; i++) begin
         if (low_bit[i]) begin
            rsp_ch.word = rsp_ch.word | tok_ff[i];
         end
      end
      rsp_fire = rsp_ch.valid && rsp_ch.ready;
      ser_free = (mask_ff == '0) || (rsp_fire && rsp_ch.last_word);
   end

   // Load a new spelling when the previous one is done, else retire words.
   always_comb begin
      mask_in = mask_ff;
      tok_in  = tok_ff;
      if (vld_ff[LAST_STG] && ser_free) begin
         mask_in = slot_vld;
         tok_in  = slot_tok;
      end else if (rsp_fire) begin
         mask_in = mask_ff & ~low_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
   end

endmodule
